// ===== src/csr_pkg.sv =====
// Shared constants and helper functions for the calculator seven-segment readout.
package csr_pkg;

    localparam int OPERAND_WIDTH = 27;
    localparam int WORD_WIDTH    = 32;
    localparam int BCD_DIGITS    = 10;
    localparam int DIGIT_IDX_W   = 4;

    localparam int OPERAND_DIGITS_DEF = 8;
    localparam int RESULT_DIGITS_DEF  = 10;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_POW = 3'd4;

    localparam logic [1:0] WHICH_A      = 2'd0;
    localparam logic [1:0] WHICH_B      = 2'd1;
    localparam logic [1:0] WHICH_RESULT = 2'd2;

    localparam logic [6:0] DASH_PATTERN = 7'h40;

    // Largest value with n decimal digits, evaluated at elaboration.
    function automatic logic [WORD_WIDTH-1:0] max_decimal(input int n);
        logic [WORD_WIDTH-1:0] v;
        v = 1;
        for (int i = 0; i < n; i++)
        begin
            v = v * 10;
        end
        return v - 1;
    endfunction

    // Segment pattern, bit 0 is segment a through bit 6 segment g.
    function automatic logic [6:0] seg_pattern(input logic [3:0] d);
        logic [6:0] s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

// ===== src/calculator_seven_segment_readout.sv =====
// Top level of the calculator seven-segment readout: arithmetic, BCD conversion, digit output.
module calculator_seven_segment_readout #(
    parameter int OPERAND_DIGITS = csr_pkg::OPERAND_DIGITS_DEF,
    parameter int RESULT_DIGITS  = csr_pkg::RESULT_DIGITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [csr_pkg::OPERAND_WIDTH-1:0]  operand_a,
    input  logic [csr_pkg::OPERAND_WIDTH-1:0]  operand_b,
    input  logic [2:0]                         command,
    output logic                               strobe,
    output logic [1:0]                         which_number,
    output logic [3:0]                         digit,
    output logic [6:0]                         segments,
    output logic                               error,
    output logic                               last
);
    // How to use this block.
    // A command word (operand_a, operand_b, command) is taken at a rising edge where
    // start is high and busy is low. Operands above the largest OPERAND_DIGITS-digit
    // value are clamped to it, and the clamped value is both shown and used.
    // The block then sends one word per displayed digit: operand A, operand B, then the
    // result, most significant digit first with leading zeros suppressed. Each word is
    // on the output ports for exactly one cycle with strobe high; the receiver must
    // take it then, since it cannot hold the block off. The final result word carries
    // last. A negative difference, a divide by zero or an unknown command replaces the
    // result digits with a single dash word that has error set.
    // Sequence: add and subtract finish in the calculate state, multiply runs a shift-add
    // multiplier, divide a restoring divider, and power a check state, then a shift-add
    // multiply for each set exponent bit and a shift-add square for every exponent bit.
    // Each number is then converted by bit-serial double dabble, its suppressed leading
    // zeros are skipped one at a time, the first shown digit is found and its digits are sent.
    // busy stays high until the last word is placed on the ports.
    // Reset returns the controller to idle and drops strobe; no word is in flight.
    import csr_pkg::*;

    localparam logic [WORD_WIDTH-1:0]  OP_LIMIT = max_decimal(OPERAND_DIGITS);
    localparam logic [DIGIT_IDX_W-1:0] OP_TOP   = DIGIT_IDX_W'(OPERAND_DIGITS - 1);
    localparam logic [DIGIT_IDX_W-1:0] RES_TOP  = DIGIT_IDX_W'(RESULT_DIGITS - 1);

    // Controller states.
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CALC    = 4'd1;
    localparam logic [3:0] S_MUL     = 4'd2;
    localparam logic [3:0] S_DIV     = 4'd3;
    localparam logic [3:0] S_PCHK    = 4'd4;
    localparam logic [3:0] S_CONV_LD = 4'd5;
    localparam logic [3:0] S_CONV    = 4'd6;
    localparam logic [3:0] S_SKIP    = 4'd7;
    localparam logic [3:0] S_EMIT    = 4'd8;
    localparam logic [3:0] S_ERR     = 4'd9;

    // Where the shared multiplier hands its product.
    localparam logic [1:0] RET_PROD = 2'd0;
    localparam logic [1:0] RET_ACC  = 2'd1;
    localparam logic [1:0] RET_SQ   = 2'd2;

    logic [3:0]                   state_reg, state_next;
    logic [OPERAND_WIDTH-1:0]     a_reg, a_next;
    logic [OPERAND_WIDTH-1:0]     b_reg, b_next;
    logic [2:0]                   cmd_reg, cmd_next;
    logic                         bad_reg, bad_next;
    logic [WORD_WIDTH-1:0]        r_reg, r_next;
    logic [WORD_WIDTH-1:0]        sq_reg, sq_next;
    logic [OPERAND_WIDTH-1:0]     ex_reg, ex_next;
    logic [WORD_WIDTH-1:0]        mx_reg, mx_next;
    logic [WORD_WIDTH-1:0]        my_reg, my_next;
    logic [WORD_WIDTH-1:0]        mp_reg, mp_next;
    logic [1:0]                   ret_reg, ret_next;
    logic [OPERAND_WIDTH-1:0]     rem_reg, rem_next;
    logic [OPERAND_WIDTH-1:0]     quo_reg, quo_next;
    logic [5:0]                   cnt_reg, cnt_next;
    logic [WORD_WIDTH-1:0]        bin_reg, bin_next;
    logic [4*BCD_DIGITS-1:0]      bcd_reg, bcd_next;
    logic [1:0]                   num_reg, num_next;
    logic [DIGIT_IDX_W-1:0]       idx_reg, idx_next;

    logic                         strobe_reg, strobe_next;
    logic [1:0]                   which_reg, which_next;
    logic [3:0]                   digit_reg, digit_next;
    logic [6:0]                   seg_reg, seg_next;
    logic                         error_reg, error_next;
    logic                         last_reg, last_next;

    logic [OPERAND_WIDTH-1:0]     a_sat, b_sat;
    logic [4*BCD_DIGITS-1:0]      bcd_adj;
    logic [3:0]                   cur_digit;
    logic [OPERAND_WIDTH:0]       div_shift;
    logic [OPERAND_WIDTH:0]       div_trial;
    logic                         div_ge;

    // Clamp oversized operands at the door.
    assign a_sat = ({{(WORD_WIDTH-OPERAND_WIDTH){1'b0}}, operand_a} > OP_LIMIT)
                   ? OP_LIMIT[OPERAND_WIDTH-1:0] : operand_a;
    assign b_sat = ({{(WORD_WIDTH-OPERAND_WIDTH){1'b0}}, operand_b} > OP_LIMIT)
                   ? OP_LIMIT[OPERAND_WIDTH-1:0] : operand_b;

    // Double dabble: every BCD digit of five or more gets three added before the shift.
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ? bcd_reg[i*4 +: 4] + 4'd3
                                                            : bcd_reg[i*4 +: 4];
        end
    end

    assign cur_digit = bcd_reg[idx_reg*4 +: 4];

    // One restoring division step: bring down the next dividend bit and try the divisor.
    assign div_shift = {rem_reg, quo_reg[OPERAND_WIDTH-1]};
    assign div_trial = div_shift - {1'b0, b_reg};
    assign div_ge    = (div_shift >= {1'b0, b_reg});

    always_comb
    begin
        state_next  = state_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        cmd_next    = cmd_reg;
        bad_next    = bad_reg;
        r_next      = r_reg;
        sq_next     = sq_reg;
        ex_next     = ex_reg;
        mx_next     = mx_reg;
        my_next     = my_reg;
        mp_next     = mp_reg;
        ret_next    = ret_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        bin_next    = bin_reg;
        bcd_next    = bcd_reg;
        num_next    = num_reg;
        idx_next    = idx_reg;
        strobe_next = 1'b0;
        which_next  = which_reg;
        digit_next  = digit_reg;
        seg_next    = seg_reg;
        error_next  = error_reg;
        last_next   = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    a_next     = a_sat;
                    b_next     = b_sat;
                    cmd_next   = command;
                    num_next   = WHICH_A;
                    state_next = S_CALC;
                end
            end

            S_CALC:
            begin
                bad_next   = 1'b0;
                state_next = S_CONV_LD;
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        r_next = WORD_WIDTH'(a_reg) + WORD_WIDTH'(b_reg);
                    end
                    CMD_SUB:
                    begin
                        if (a_reg < b_reg)
                        begin
                            bad_next = 1'b1;
                        end
                        else
                        begin
                            r_next = WORD_WIDTH'(a_reg - b_reg);
                        end
                    end
                    CMD_MUL:
                    begin
                        mx_next    = WORD_WIDTH'(a_reg);
                        my_next    = WORD_WIDTH'(b_reg);
                        mp_next    = '0;
                        ret_next   = RET_PROD;
                        state_next = S_MUL;
                    end
                    CMD_DIV:
                    begin
                        if (b_reg == '0)
                        begin
                            bad_next = 1'b1;
                        end
                        else
                        begin
                            rem_next   = '0;
                            quo_next   = a_reg;
                            cnt_next   = '0;
                            state_next = S_DIV;
                        end
                    end
                    CMD_POW:
                    begin
                        r_next     = WORD_WIDTH'(1);
                        sq_next    = WORD_WIDTH'(a_reg);
                        ex_next    = b_reg;
                        state_next = S_PCHK;
                    end
                    default:
                    begin
                        bad_next = 1'b1;
                    end
                endcase
            end

            // Shift-add multiplier, done when no multiplier bits remain.
            S_MUL:
            begin
                if (my_reg == '0)
                begin
                    case (ret_reg)
                        RET_ACC:
                        begin
                            r_next   = mp_reg;
                            mx_next  = sq_reg;
                            my_next  = sq_reg;
                            mp_next  = '0;
                            ret_next = RET_SQ;
                        end
                        RET_SQ:
                        begin
                            sq_next    = mp_reg;
                            ex_next    = ex_reg >> 1;
                            state_next = S_PCHK;
                        end
                        default:
                        begin
                            r_next     = mp_reg;
                            state_next = S_CONV_LD;
                        end
                    endcase
                end
                else
                begin
                    if (my_reg[0])
                    begin
                        mp_next = mp_reg + mx_reg;
                    end
                    mx_next = mx_reg << 1;
                    my_next = my_reg >> 1;
                end
            end

            S_DIV:
            begin
                rem_next = div_ge ? div_trial[OPERAND_WIDTH-1:0]
                                  : div_shift[OPERAND_WIDTH-1:0];
                quo_next = {quo_reg[OPERAND_WIDTH-2:0], div_ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(OPERAND_WIDTH - 1))
                begin
                    r_next     = WORD_WIDTH'({quo_reg[OPERAND_WIDTH-2:0], div_ge});
                    state_next = S_CONV_LD;
                end
            end

            // Square-and-multiply over the exponent bits, low bit first.
            S_PCHK:
            begin
                mp_next    = '0;
                state_next = S_MUL;
                if (ex_reg == '0)
                begin
                    state_next = S_CONV_LD;
                end
                else if (ex_reg[0])
                begin
                    mx_next  = r_reg;
                    my_next  = sq_reg;
                    ret_next = RET_ACC;
                end
                else
                begin
                    mx_next  = sq_reg;
                    my_next  = sq_reg;
                    ret_next = RET_SQ;
                end
            end

            S_CONV_LD:
            begin
                case (num_reg)
                    WHICH_A: bin_next = WORD_WIDTH'(a_reg);
                    WHICH_B: bin_next = WORD_WIDTH'(b_reg);
                    default: bin_next = r_reg;
                endcase
                bcd_next   = '0;
                cnt_next   = '0;
                state_next = S_CONV;
            end

            S_CONV:
            begin
                bcd_next = {bcd_adj[4*BCD_DIGITS-2:0], bin_reg[WORD_WIDTH-1]};
                bin_next = bin_reg << 1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(WORD_WIDTH - 1))
                begin
                    idx_next   = (num_reg == WHICH_RESULT) ? RES_TOP : OP_TOP;
                    state_next = S_SKIP;
                end
            end

            // Walk past leading zeros; the units digit is always shown.
            S_SKIP:
            begin
                if ((idx_reg != '0) && (cur_digit == 4'd0))
                begin
                    idx_next = idx_reg - DIGIT_IDX_W'(1);
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                strobe_next = 1'b1;
                which_next  = num_reg;
                digit_next  = cur_digit;
                seg_next    = seg_pattern(cur_digit);
                error_next  = 1'b0;
                last_next   = (num_reg == WHICH_RESULT) && (idx_reg == '0);
                if (idx_reg != '0)
                begin
                    idx_next = idx_reg - DIGIT_IDX_W'(1);
                end
                else if (num_reg == WHICH_RESULT)
                begin
                    state_next = S_IDLE;
                end
                else if ((num_reg == WHICH_B) && bad_reg)
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    num_next   = num_reg + 2'd1;
                    state_next = S_CONV_LD;
                end
            end

            S_ERR:
            begin
                strobe_next = 1'b1;
                which_next  = WHICH_RESULT;
                digit_next  = 4'd0;
                seg_next    = DASH_PATTERN;
                error_next  = 1'b1;
                last_next   = 1'b1;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        cmd_reg   <= cmd_next;
        bad_reg   <= bad_next;
        r_reg     <= r_next;
        sq_reg    <= sq_next;
        ex_reg    <= ex_next;
        mx_reg    <= mx_next;
        my_reg    <= my_next;
        mp_reg    <= mp_next;
        ret_reg   <= ret_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        bin_reg   <= bin_next;
        bcd_reg   <= bcd_next;
        num_reg   <= num_next;
        idx_reg   <= idx_next;
        which_reg <= which_next;
        digit_reg <= digit_next;
        seg_reg   <= seg_next;
        error_reg <= error_next;
        last_reg  <= last_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign strobe       = strobe_reg;
    assign which_number = which_reg;
    assign digit        = digit_reg;
    assign segments     = seg_reg;
    assign error        = error_reg;
    assign last         = last_reg;

endmodule

// ===== bench/tb_calculator_seven_segment_readout.sv =====
// Testbench for the calculator seven-segment readout: random and directed commands checked digit by digit.
`timescale 1ns / 1ps

module tb_calculator_seven_segment_readout;
    import csr_pkg::*;

    // One displayed digit as the block should produce it.
    typedef struct packed {
        logic [1:0] which;
        logic [3:0] dig;
        logic [6:0] seg;
        logic       err;
        logic       fin;
    } digit_word_t;

    localparam int  WATCHDOG_LIMIT = 20000;
    localparam int  DRAIN_CYCLES   = 200;
    localparam logic [2:0] CMD_BAD5 = 3'd5;
    localparam logic [2:0] CMD_BAD7 = 3'd7;
    localparam logic [63:0] OPERAND_MAX = 64'd99999999;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [OPERAND_WIDTH-1:0] operand_a;
    logic [OPERAND_WIDTH-1:0] operand_b;
    logic [2:0] command;
    logic strobe;
    logic [1:0] which_number;
    logic [3:0] digit;
    logic [6:0] segments;
    logic error;
    logic last;

    digit_word_t expected_digits[$];
    int mismatch_count;
    int words_sent;
    int digits_seen;
    int idle_cycles;
    int gap_percent;

    calculator_seven_segment_readout i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operand_a(operand_a), .operand_b(operand_b), .command(command),
        .strobe(strobe), .which_number(which_number), .digit(digit),
        .segments(segments), .error(error), .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Segment patterns are written out here independently of the package helper.
    function automatic logic [6:0] glyph_of(input int d);
        logic [6:0] g[10];
        g = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};
        return g[d];
    endfunction

    // Append the digits of value, most significant first, with leading zeros dropped.
    function automatic void queue_number(input logic [1:0] which, input logic [63:0] value,
                                         input bit mark_last);
        int nd;
        logic [63:0] scale;
        int d;
        nd = 1;
        scale = 64'd1;
        while (value / scale >= 64'd10)
        begin
            scale = scale * 10;
            nd++;
        end
        for (int i = nd - 1; i >= 0; i--)
        begin
            d = int'((value / scale) % 10);
            expected_digits.push_back('{which, d[3:0], glyph_of(d), 1'b0,
                                        mark_last && (i == 0)});
            scale = scale / 10;
        end
    endfunction

    // Work out the full digit stream that one command word should produce.
    function automatic void predict_readout(input logic [26:0] a_in, input logic [26:0] b_in,
                                            input logic [2:0] cmd);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        logic [63:0] sq;
        logic [63:0] ex;
        bit bad;
        a = (a_in > OPERAND_MAX) ? OPERAND_MAX : 64'(a_in);
        b = (b_in > OPERAND_MAX) ? OPERAND_MAX : 64'(b_in);
        r = 0;
        bad = 1'b0;
        case (cmd)
            CMD_ADD: r = (a + b) & 64'hFFFF_FFFF;
            CMD_SUB:
            begin
                if (a < b) bad = 1'b1;
                else r = a - b;
            end
            CMD_MUL: r = (a * b) & 64'hFFFF_FFFF;
            CMD_DIV:
            begin
                if (b == 0) bad = 1'b1;
                else r = a / b;
            end
            CMD_POW:
            begin
                // Square-and-multiply keeping only the low 32 bits.
                r = 64'd1;
                sq = a;
                ex = b;
                while (ex != 0)
                begin
                    if (ex[0]) r = (r * sq) & 64'hFFFF_FFFF;
                    sq = (sq * sq) & 64'hFFFF_FFFF;
                    ex = ex >> 1;
                end
            end
            default: bad = 1'b1;
        endcase
        queue_number(WHICH_A, a, 1'b0);
        queue_number(WHICH_B, b, 1'b0);
        if (bad)
            expected_digits.push_back('{WHICH_RESULT, 4'd0, DASH_PATTERN, 1'b1, 1'b1});
        else
            queue_number(WHICH_RESULT, r % 64'd10000000000, 1'b1);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    // Every strobed digit is compared with the oldest expected one.
    always @(posedge clk)
    begin
        digit_word_t want;
        if (rst_n && strobe)
        begin
            digits_seen++;
            if (expected_digits.size() == 0)
                report_mismatch("digit strobed with nothing expected");
            else
            begin
                want = expected_digits.pop_front();
                if (which_number !== want.which)
                    report_mismatch($sformatf("which_number %0d, want %0d",
                                              which_number, want.which));
                if (digit !== want.dig)
                    report_mismatch($sformatf("digit %0d, want %0d", digit, want.dig));
                if (segments !== want.seg)
                    report_mismatch($sformatf("segments %h, want %h", segments, want.seg));
                if (error !== want.err)
                    report_mismatch($sformatf("error %b, want %b", error, want.err));
                if (last !== want.fin)
                    report_mismatch($sformatf("last %b, want %b", last, want.fin));
            end
        end
    end

    // The watchdog counts cycles in which no word and no digit moves.
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d digits pending", expected_digits.size());
            $display("FAIL calculator_seven_segment_readout");
            $finish;
        end
    end

    // Drive one command word at the falling edge and hold it until the block takes it.
    task automatic send_word(input logic [26:0] a, input logic [26:0] b, input logic [2:0] cmd);
        @(negedge clk);
        while ($urandom_range(99) < gap_percent)
            @(negedge clk);
        operand_a <= a;
        operand_b <= b;
        command <= cmd;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_readout(a, b, cmd);
        words_sent++;
        @(negedge clk);
        start <= 1'b0;
    endtask

    // Operands biased toward short values so that every digit count shows up.
    function automatic logic [26:0] pick_operand();
        case ($urandom_range(5))
            0: return 27'($urandom_range(9));
            1: return 27'($urandom_range(999));
            2: return 27'($urandom_range(99999));
            3: return 27'($urandom_range(99999999));
            4: return 27'($urandom);
            default: return 27'($urandom_range(20));
        endcase
    endfunction

    task automatic test_operand_extremes();
        send_word(27'd0, 27'd0, CMD_ADD);
        send_word(27'd99999999, 27'd99999999, CMD_ADD);
        send_word(27'h7FFFFFF, 27'h7FFFFFF, CMD_MUL);
        send_word(27'd100000000, 27'd1, CMD_SUB);
        send_word(27'd1234567, 27'd890, CMD_ADD);
    endtask

    task automatic test_each_command();
        send_word(27'd9876, 27'd1234, CMD_SUB);
        send_word(27'd5, 27'd5, CMD_SUB);
        send_word(27'd3, 27'd4, CMD_SUB);
        send_word(27'd99999, 27'd99999, CMD_MUL);
        send_word(27'd100, 27'd7, CMD_DIV);
        send_word(27'd6, 27'd0, CMD_DIV);
        send_word(27'd0, 27'd0, CMD_DIV);
        send_word(27'd2, 27'd31, CMD_POW);
        send_word(27'd2, 27'd32, CMD_POW);
        send_word(27'd0, 27'd0, CMD_POW);
        send_word(27'd7, 27'd99999999, CMD_POW);
        send_word(27'd1, 27'd1, CMD_BAD5);
        send_word(27'd1, 27'd1, 3'd6);
        send_word(27'd12, 27'd34, CMD_BAD7);
    endtask

    task automatic test_all_digits();
        // Every digit 0 through 9 appears in these numbers.
        send_word(27'd12345678, 27'd90, CMD_ADD);
        send_word(27'd66666666, 27'd1, CMD_MUL);
        send_word(27'd99999999, 27'd43, CMD_MUL);
    endtask

    task automatic test_random_words(input int count);
        logic [2:0] cmd;
        for (int i = 0; i < count; i++)
        begin
            cmd = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5))
                                           : 3'($urandom_range(4));
            send_word(pick_operand(), pick_operand(), cmd);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        operand_a = '0;
        operand_b = '0;
        command = CMD_ADD;
        mismatch_count = 0;
        words_sent = 0;
        digits_seen = 0;
        idle_cycles = 0;
        gap_percent = 9;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_operand_extremes();
        test_each_command();
        test_all_digits();
        // The sender gaps rarely, then often, then never.
        test_random_words(150);
        gap_percent = 55;
        test_random_words(150);
        gap_percent = 0;
        test_random_words(150);

        while (expected_digits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d command words and %0d strobed digits, all five operations,",
                 words_sent, digits_seen);
        $display("error cases, saturated operands and wrapped products");
        if (mismatch_count == 0 && expected_digits.size() == 0)
            $display("PASS calculator_seven_segment_readout");
        else
            $display("FAIL calculator_seven_segment_readout");
        $finish;
    end

endmodule
